@@ rtl/bgs_pkg.sv @@
// Shared types, constants and helpers for the bilinear gray scaler.
// Used by bgs_ctrl, bgs_dpath and bilinear_gray_scaler; depends on nothing.

package bgs_pkg;

  // Frame store geometry and fixed-point format
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 16;

  // Field widths fixed by the interface
  localparam int ROW_W      = 12;
  localparam int COL_W      = 12;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 9;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Derived widths
  localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int RIDX_W   = $clog2(MAX_HEIGHT);
  localparam int CIDX_W   = $clog2(MAX_WIDTH);
  localparam int HEFF_W   = $clog2(MAX_HEIGHT + 1);
  localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
  localparam int VPOS_W   = ROW_W + STEP_W;
  localparam int HPOS_W   = COL_W + STEP_W;
  localparam int WGT_W    = FRAC_BITS + 1;
  localparam int ROWSUM_W = PIX_W + FRAC_BITS;
  localparam int ACC_W    = PIX_W + 2 * FRAC_BITS;

  localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

  // Register reset values
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_VERT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_HORZ  = 2'd3;

  // Request and status codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_RANGE  = 1'b1;

  // Neighbour tap codes: bit 1 selects the lower row, bit 0 the right column
  localparam logic [1:0] TAP_00 = 2'd0;
  localparam logic [1:0] TAP_01 = 2'd1;
  localparam logic [1:0] TAP_10 = 2'd2;
  localparam logic [1:0] TAP_11 = 2'd3;

  typedef struct packed {
    logic             req_type;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel_in;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             status;
  } out_word_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       idx;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       mac_en;
    logic [1:0] mac_sel;
    logic       vert;
    logic       wr_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic wr_ok;
  } stat_t;

  // Zero reads as one, anything above the maximum as the maximum
  function automatic int clamp_size(logic [SIZE_W-1:0] v, int mx);
    int r;
    r = int'(v);
    if (r == 0) r = 1;
    else if (r > mx) r = mx;
    return r;
  endfunction

endpackage

@@ rtl/bgs_ctrl.sv @@
// Sequencer for the bilinear gray scaler: handshakes and datapath commands.
// Depends on bgs_pkg; drives bgs_dpath through cmd_t and reads stat_t.

module bgs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_read,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bgs_pkg::stat_t stat,
  output bgs_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_IDX  = 4'd2;
  localparam logic [3:0] S_RD0  = 4'd3;
  localparam logic [3:0] S_RD1  = 4'd4;
  localparam logic [3:0] S_RD2  = 4'd5;
  localparam logic [3:0] S_RD3  = 4'd6;
  localparam logic [3:0] S_MAC3 = 4'd7;
  localparam logic [3:0] S_VERT = 4'd8;
  localparam logic [3:0] S_WR   = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_read == bgs_pkg::REQ_READ) ? S_MUL : S_WR;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx   = 1'b1;
        state_nxt = S_RD0;
      end
      // read data lands in the cycle after the address, so each MAC step follows its RD step
      S_RD0: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = bgs_pkg::TAP_00;
        state_nxt  = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = bgs_pkg::TAP_01;
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = bgs_pkg::TAP_00;
        state_nxt   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = bgs_pkg::TAP_10;
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = bgs_pkg::TAP_01;
        state_nxt   = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_sel  = bgs_pkg::TAP_11;
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = bgs_pkg::TAP_10;
        state_nxt   = S_MAC3;
      end
      S_MAC3: begin
        cmd.mac_en  = 1'b1;
        cmd.mac_sel = bgs_pkg::TAP_11;
        state_nxt   = S_VERT;
      end
      S_VERT: begin
        cmd.vert  = 1'b1;
        state_nxt = S_DONE;
      end
      S_WR: begin
        cmd.wr_en = stat.wr_ok;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL || state_r == S_WR))
    else $error("accepted word did not start work");

  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> (stat.wr_ok && !stat.is_read))
    else $error("frame store written by a bad request");

  a_rd_only_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_en || cmd.mac_en || cmd.vert) |-> stat.is_read)
    else $error("interpolation step on a write request");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the done step");

endmodule

@@ rtl/bgs_dpath.sv @@
// Datapath for the bilinear gray scaler: registers, frame store, multipliers.
// Depends on bgs_pkg; sequenced by bgs_ctrl through cmd_t.

module bgs_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  bgs_pkg::in_word_t             in_word,
  input  bgs_pkg::cmd_t                 cmd,
  output bgs_pkg::stat_t                stat,
  output bgs_pkg::out_word_t            out_word
);

  // configuration
  logic [bgs_pkg::SIZE_W-1:0] src_w_r, src_h_r;
  logic [bgs_pkg::STEP_W-1:0] step_v_r, step_h_r;

  // latched request
  bgs_pkg::in_word_t req_r;

  // position, indices and fractions
  logic [bgs_pkg::VPOS_W-1:0]    pv_r;
  logic [bgs_pkg::HPOS_W-1:0]    ph_r;
  logic [bgs_pkg::RIDX_W-1:0]    r0_r, r1_r, r0_c, r1_c;
  logic [bgs_pkg::CIDX_W-1:0]    c0_r, c1_r, c0_c, c1_c;
  logic [bgs_pkg::FRAC_BITS-1:0] fh_r, fw_r;

  // blend
  logic [bgs_pkg::PIX_W-1:0]    mem_q_r;
  logic [bgs_pkg::ROWSUM_W-1:0] top_r, bot_r;
  logic [bgs_pkg::ACC_W-1:0]    acc_r;
  bgs_pkg::out_word_t           out_r;

  logic [bgs_pkg::HEFF_W-1:0] h_eff;
  logic [bgs_pkg::WEFF_W-1:0] w_eff;
  logic [bgs_pkg::RIDX_W-1:0] h_last;
  logic [bgs_pkg::CIDX_W-1:0] w_last;
  logic [bgs_pkg::VPOS_W-bgs_pkg::FRAC_BITS-1:0] vint;
  logic [bgs_pkg::HPOS_W-bgs_pkg::FRAC_BITS-1:0] hint;

  logic [bgs_pkg::WGT_W-1:0] wgt_w0, wgt_w1, wgt_h0, wgt_h1, mac_wgt;
  logic [bgs_pkg::PIX_W+bgs_pkg::WGT_W-1:0]    mac_prod;
  logic [bgs_pkg::ROWSUM_W-1:0]                mac_term;
  logic [bgs_pkg::ROWSUM_W+bgs_pkg::WGT_W-1:0] vt, vb;

  logic [bgs_pkg::ADDR_W-1:0] wr_addr, rd_addr, mem_addr;
  logic [bgs_pkg::RIDX_W-1:0] rd_row;
  logic [bgs_pkg::CIDX_W-1:0] rd_col;
  logic [bgs_pkg::PIX_W-1:0]  mem [0:bgs_pkg::DEPTH-1];

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= bgs_pkg::SIZE_RESET;
      src_h_r  <= bgs_pkg::SIZE_RESET;
      step_v_r <= bgs_pkg::STEP_RESET;
      step_h_r <= bgs_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgs_pkg::CFG_SRC_WIDTH:  src_w_r  <= cfg_wdata[bgs_pkg::SIZE_W-1:0];
        bgs_pkg::CFG_SRC_HEIGHT: src_h_r  <= cfg_wdata[bgs_pkg::SIZE_W-1:0];
        bgs_pkg::CFG_STEP_VERT:  step_v_r <= cfg_wdata[bgs_pkg::STEP_W-1:0];
        bgs_pkg::CFG_STEP_HORZ:  step_h_r <= cfg_wdata[bgs_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign h_eff  = bgs_pkg::HEFF_W'(bgs_pkg::clamp_size(src_h_r, bgs_pkg::MAX_HEIGHT));
  assign w_eff  = bgs_pkg::WEFF_W'(bgs_pkg::clamp_size(src_w_r, bgs_pkg::MAX_WIDTH));
  assign h_last = bgs_pkg::RIDX_W'(h_eff - bgs_pkg::HEFF_W'(1));
  assign w_last = bgs_pkg::CIDX_W'(w_eff - bgs_pkg::WEFF_W'(1));

  assign stat.is_read = (req_r.req_type == bgs_pkg::REQ_READ);
  assign stat.wr_ok   = (32'(req_r.row) < 32'(h_eff)) && (32'(req_r.col) < 32'(w_eff));

  // ---------------- index and fraction ----------------
  assign vint = pv_r[bgs_pkg::VPOS_W-1:bgs_pkg::FRAC_BITS];
  assign hint = ph_r[bgs_pkg::HPOS_W-1:bgs_pkg::FRAC_BITS];

  always_comb begin
    r0_c = (32'(vint) > 32'(h_last)) ? h_last : bgs_pkg::RIDX_W'(vint);
    c0_c = (32'(hint) > 32'(w_last)) ? w_last : bgs_pkg::CIDX_W'(hint);
    r1_c = (r0_c == h_last) ? r0_c : r0_c + bgs_pkg::RIDX_W'(1);
    c1_c = (c0_c == w_last) ? c0_c : c0_c + bgs_pkg::CIDX_W'(1);
  end

  // ---------------- weights ----------------
  assign wgt_w1 = {1'b0, fw_r};
  assign wgt_w0 = bgs_pkg::ONE - wgt_w1;
  assign wgt_h1 = {1'b0, fh_r};
  assign wgt_h0 = bgs_pkg::ONE - wgt_h1;

  // right-column taps take fw, left-column taps take 1-fw
  assign mac_wgt  = cmd.mac_sel[0] ? wgt_w1 : wgt_w0;
  assign mac_prod = mem_q_r * mac_wgt;
  assign mac_term = bgs_pkg::ROWSUM_W'(mac_prod);

  assign vt = top_r * wgt_h0;
  assign vb = bot_r * wgt_h1;

  // ---------------- frame store ----------------
  assign wr_addr  = bgs_pkg::ADDR_W'(32'(req_r.row) * bgs_pkg::MAX_WIDTH + 32'(req_r.col));
  assign rd_row   = cmd.rd_sel[1] ? r1_r : r0_r;
  assign rd_col   = cmd.rd_sel[0] ? c1_r : c0_r;
  assign rd_addr  = bgs_pkg::ADDR_W'(32'(rd_row) * bgs_pkg::MAX_WIDTH + 32'(rd_col));
  assign mem_addr = cmd.wr_en ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[mem_addr] <= req_r.pixel_in;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_word;
    end
    if (cmd.mul) begin
      pv_r <= req_r.row * step_v_r;
      ph_r <= req_r.col * step_h_r;
    end
    if (cmd.idx) begin
      r0_r <= r0_c;
      r1_r <= r1_c;
      c0_r <= c0_c;
      c1_r <= c1_c;
      fh_r <= pv_r[bgs_pkg::FRAC_BITS-1:0];
      fw_r <= ph_r[bgs_pkg::FRAC_BITS-1:0];
    end
    if (cmd.mac_en) begin
      case (cmd.mac_sel)
        bgs_pkg::TAP_00: top_r <= mac_term;
        bgs_pkg::TAP_01: top_r <= top_r + mac_term;
        bgs_pkg::TAP_10: bot_r <= mac_term;
        bgs_pkg::TAP_11: bot_r <= bot_r + mac_term;
        default: ;
      endcase
    end
    if (cmd.vert) begin
      acc_r <= bgs_pkg::ACC_W'(vt + vb);
    end
    if (cmd.out_load) begin
      if (stat.is_read) begin
        out_r.pixel_out <= acc_r[bgs_pkg::ACC_W-1 -: bgs_pkg::PIX_W];
        out_r.status    <= bgs_pkg::ST_OK;
      end else begin
        out_r.pixel_out <= '0;
        out_r.status    <= stat.wr_ok ? bgs_pkg::ST_OK : bgs_pkg::ST_RANGE;
      end
    end
  end

  assign out_word = out_r;

endmodule

@@ rtl/bilinear_gray_scaler.sv @@
// Bilinear gray scaler: a frame store of 8-bit source pixels and a bilinear
// read-out of scaled output pixels, one result word for every request word.
//
// Input channel (in_valid / in_stall / in_word): req_type 0 stores pixel_in at
// (row, col) of the source image; req_type 1 asks for output pixel (row, col).
// Output channel (out_valid / out_stall / out_word): pixel_out and status; a
// write answers pixel 0 with status 0, or status 1 when outside the source size.
// Configuration (cfg_we / cfg_index / cfg_wdata): source width and height and the
// Q8.16 vertical and horizontal steps; write only while the block is idle.
//
// Sequence: a write goes through accept, store and done steps; a read through
// accept, multiply, clamp, four neighbour fetches through the single port of
// the frame store with the blend trailing each, vertical mix and done. A result
// is loaded into the output register in the done step. The output register
// lets the next word be taken while a result waits; a stalled receiver holds
// the block in its last step once a second result is ready.
// Reset clears the sequencer, the output valid and the configuration to 256,
// 256, 1.0, 1.0; the frame store is not cleared and must be written first.
// Depends on bgs_pkg, bgs_ctrl and bgs_dpath.

module bilinear_gray_scaler (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bgs_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bgs_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bgs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bgs_pkg::cmd_t  cmd;
  bgs_pkg::stat_t stat;

  bgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_read   (in_word.req_type),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bgs_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

endmodule
